// ===== sv/ffba_pkg.sv =====
// Shared codes and field widths for the first-fit block allocator.
package ffba_pkg;

    localparam int REQ_W  = 2;
    localparam int SIZE_W = 26;
    localparam int ADDR_W = 32;
    localparam int STAT_W = 2;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TAKE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FREE  = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd1;
    localparam logic [STAT_W-1:0] ST_OUTSIDE = 2'd2;

    // Register index, taken from paddr[2]
    localparam logic CFG_REGION_BASE = 1'b0;
    localparam logic CFG_TAKE_BASE   = 1'b1;

    localparam logic [ADDR_W-1:0] TAKE_BASE_RESET = 32'h0200_0000;

endpackage

// ===== sv/ffba_run_map.sv =====
// Run-length map memory with a zeroing sweep after reset.
module ffba_run_map #(
    parameter int DEPTH = 32768,
    parameter int AW    = 15,
    parameter int DW    = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    output logic          clear_busy
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;
    logic [AW-1:0] clr_addr_reg;
    logic          clr_busy_reg;

    // zeroing sweep, one entry a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data    = rd_data_reg;
    assign clear_busy = clr_busy_reg;

endmodule

// ===== sv/first_fit_block_allocator_core.sv =====
// First-fit block allocator: request sequencer, config registers and run map.
//
// Manages REGION_BYTES of space as blocks of BLOCK_BYTES (a power of two).
// One request word is worked on at a time. An allocate walks the run map
// one entry per cycle through the single read port of the map memory,
// pausing its reads after each allocation it jumps over. After reset the
// map is zeroed by a sweep over its REGION_BYTES / BLOCK_BYTES entries
// (32768 at the defaults), during which in_ready stays low; config writes
// are taken as usual. The result word is held in an output register, so
// the next request is accepted while it waits.
// Registers: 0x0 region_base, 0x4 take_base.
module first_fit_block_allocator_core #(
    parameter int BLOCK_BYTES  = 1024,
    parameter int REGION_BYTES = 33554432
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // request channel
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [ffba_pkg::REQ_W-1:0]  req_type,
    input  logic [ffba_pkg::SIZE_W-1:0] size_bytes,
    input  logic [ffba_pkg::ADDR_W-1:0] address,
    // result channel
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ffba_pkg::STAT_W-1:0] status,
    output logic [ffba_pkg::ADDR_W-1:0] result_address,
    // config port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    import ffba_pkg::*;

    localparam int LOG2BB       = $clog2(BLOCK_BYTES);
    localparam int NBLK         = REGION_BYTES / BLOCK_BYTES;
    localparam int REGION_LIMIT = NBLK * BLOCK_BYTES;
    localparam int AW           = (NBLK > 1) ? $clog2(NBLK) : 1;
    localparam int CW           = $clog2(NBLK + 1);    // run length width
    localparam int SW           = CW + 2;              // scan position width
    localparam int NFW          = SIZE_W + 1;          // rounded size width

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [REQ_W-1:0]  req_type_reg, req_type_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [ADDR_W-1:0] addr_in_reg, addr_in_next;

    logic [CW-1:0]     need_reg, need_next;
    logic [SW-1:0]     pos_reg, pos_next;
    logic [SW-1:0]     end_reg, end_next;
    logic [SW-1:0]     issue_reg, issue_next;
    logic [SW-1:0]     chk_reg, chk_next;
    logic              rd_valid_reg, rd_valid_next;

    logic [STAT_W-1:0] res_status_reg, res_status_next;
    logic [ADDR_W-1:0] res_addr_reg, res_addr_next;

    logic              out_valid_reg, out_valid_next;
    logic [STAT_W-1:0] out_status_reg, out_status_next;
    logic [ADDR_W-1:0] out_addr_reg, out_addr_next;

    logic [ADDR_W-1:0] region_base_reg;
    logic [ADDR_W-1:0] take_base_reg;

    // map port
    logic          map_rd_en;
    logic [AW-1:0] map_rd_addr;
    logic [CW-1:0] map_rd_data;
    logic          map_wr_en;
    logic [AW-1:0] map_wr_addr;
    logic [CW-1:0] map_wr_data;
    logic          map_clearing;

    ffba_run_map #(
        .DEPTH (NBLK),
        .AW    (AW),
        .DW    (CW)
    ) u_map (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (map_rd_en),
        .rd_addr    (map_rd_addr),
        .rd_data    (map_rd_data),
        .wr_en      (map_wr_en),
        .wr_addr    (map_wr_addr),
        .wr_data    (map_wr_data),
        .clear_busy (map_clearing)
    );

    // ------------------------------------------------------------------
    // Config port: two 32-bit registers, index in paddr[2]
    // ------------------------------------------------------------------
    logic cfg_wr;
    assign cfg_wr = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_base_reg <= '0;
            take_base_reg   <= TAKE_BASE_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                CFG_REGION_BASE: region_base_reg <= pwdata;
                CFG_TAKE_BASE:   take_base_reg   <= pwdata;
                default:         region_base_reg <= region_base_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            CFG_REGION_BASE: prdata = region_base_reg;
            CFG_TAKE_BASE:   prdata = take_base_reg;
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Request decode helpers
    // ------------------------------------------------------------------
    logic [NFW-1:0]    size_up;
    logic [NFW-1:0]    need_full;
    logic [ADDR_W-1:0] take_off;
    logic [ADDR_W-1:0] free_off;
    logic              take_in;
    logic              free_in;
    logic [AW-1:0]     take_blk;
    logic [AW-1:0]     free_blk;
    logic [CW-1:0]     take_room;
    logic [CW-1:0]     take_run;

    assign size_up   = NFW'(size_reg) + NFW'(BLOCK_BYTES - 1);
    assign need_full = size_up >> LOG2BB;
    assign take_off  = addr_in_reg - take_base_reg;
    assign free_off  = addr_in_reg - region_base_reg;
    assign take_in   = take_off < ADDR_W'(REGION_LIMIT);
    assign free_in   = free_off < ADDR_W'(REGION_LIMIT);
    assign take_blk  = AW'(take_off >> LOG2BB);
    assign free_blk  = AW'(free_off >> LOG2BB);
    assign take_room = CW'(NBLK) - CW'(take_blk);
    // a take past the region end is cut at the end
    assign take_run  = (need_full > NFW'(take_room)) ? take_room : CW'(need_full);

    // ------------------------------------------------------------------
    // Scan helpers: the map word for chk_reg arrives this cycle
    // ------------------------------------------------------------------
    logic          scan_hit;
    logic          scan_fit;
    logic [SW-1:0] jump_pos;
    logic [SW-1:0] jump_end;
    logic [ADDR_W-1:0] pos_bytes;

    assign scan_hit  = rd_valid_reg && (map_rd_data != '0);
    assign scan_fit  = rd_valid_reg && (map_rd_data == '0) && (chk_reg == end_reg - SW'(1));
    assign jump_pos  = chk_reg + SW'(map_rd_data);
    assign jump_end  = jump_pos + SW'(need_reg);
    assign pos_bytes = ADDR_W'(pos_reg) << LOG2BB;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        req_type_next   = req_type_reg;
        size_next       = size_reg;
        addr_in_next    = addr_in_reg;
        need_next       = need_reg;
        pos_next        = pos_reg;
        end_next        = end_reg;
        issue_next      = issue_reg;
        chk_next        = chk_reg;
        rd_valid_next   = 1'b0;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        map_rd_en       = 1'b0;
        map_rd_addr     = issue_reg[AW-1:0];
        map_wr_en       = 1'b0;
        map_wr_addr     = pos_reg[AW-1:0];
        map_wr_data     = need_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    req_type_next = req_type;
                    size_next     = size_bytes;
                    addr_in_next  = address;
                    state_next    = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_status_next = ST_NOSPACE;
                res_addr_next   = '0;
                state_next      = S_DONE;
                unique case (req_type_reg)
                    REQ_ALLOC:
                    begin
                        if (size_reg != '0 && need_full <= NFW'(NBLK))
                        begin
                            need_next  = CW'(need_full);
                            pos_next   = '0;
                            end_next   = SW'(need_full);
                            issue_next = '0;
                            state_next = S_SCAN;
                        end
                    end
                    REQ_TAKE:
                    begin
                        if (size_reg != '0)
                        begin
                            if (take_in)
                            begin
                                map_wr_en       = 1'b1;
                                map_wr_addr     = take_blk;
                                map_wr_data     = take_run;
                                res_status_next = ST_OK;
                                res_addr_next   = region_base_reg + take_off;
                            end
                            else
                            begin
                                res_status_next = ST_OUTSIDE;
                            end
                        end
                    end
                    REQ_FREE:
                    begin
                        if (free_in)
                        begin
                            map_wr_en       = 1'b1;
                            map_wr_addr     = free_blk;
                            map_wr_data     = '0;
                            res_status_next = ST_OK;
                        end
                        else
                        begin
                            res_status_next = ST_OUTSIDE;
                        end
                    end
                    default:
                    begin
                        res_status_next = ST_NOSPACE;
                    end
                endcase
            end

            S_SCAN:
            begin
                if (scan_hit)
                begin
                    // jump past the run; the scan restarts its reads at the run end
                    if (jump_end > SW'(NBLK))
                    begin
                        res_status_next = ST_NOSPACE;
                        res_addr_next   = '0;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        pos_next   = jump_pos;
                        end_next   = jump_end;
                        issue_next = jump_pos;
                    end
                end
                else if (scan_fit)
                begin
                    map_wr_en       = 1'b1;
                    res_status_next = ST_OK;
                    res_addr_next   = region_base_reg + pos_bytes;
                    state_next      = S_DONE;
                end
                else if (issue_reg < end_reg)
                begin
                    map_rd_en     = 1'b1;
                    rd_valid_next = 1'b1;
                    chk_next      = issue_reg;
                    issue_next    = issue_reg + SW'(1);
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_addr_next   = res_addr_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_type_reg   <= req_type_next;
        size_reg       <= size_next;
        addr_in_reg    <= addr_in_next;
        need_reg       <= need_next;
        pos_reg        <= pos_next;
        end_reg        <= end_next;
        issue_reg      <= issue_next;
        chk_reg        <= chk_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
    end

    assign in_ready       = (state_reg == S_IDLE) && !map_clearing;
    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign result_address = out_addr_reg;

`ifndef SYNTHESIS
    // no request is taken while the map is being zeroed
    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        map_clearing |-> !in_ready)
        else $error("request accepted during map clear");

    // one request at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (!in_ready && state_reg == S_EXEC))
        else $error("second request accepted while busy");

    // scan reads stay inside the window under test
    a_scan_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && map_rd_en) |-> (issue_reg < end_reg && end_reg <= SW'(NBLK)))
        else $error("scan read outside window");

    // a failed result carries address zero
    a_zero_addr_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (result_address == '0))
        else $error("nonzero address with error status");
`endif

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the first-fit block allocator core: predictor, driver, monitor.
module tb;
    import ffba_pkg::*;

    localparam int BLOCK_BYTES  = 1024;
    localparam int REGION_BYTES = 33554432;
    localparam int NBLK         = REGION_BYTES / BLOCK_BYTES;

    // req_type value that the block must reject
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    localparam int BACKLOG_MAX = 4;    // request words queued ahead of the driver
    localparam int LONG_HOLD   = 300;  // receiver hold-off, long enough to back up the input

    typedef struct packed {
        logic [REQ_W-1:0]  kind;
        logic [SIZE_W-1:0] size_bytes;
        logic [ADDR_W-1:0] address;
    } alloc_req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] result_address;
    } alloc_rsp_t;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports. Every input has a known value at time 0.
    // ------------------------------------------------------------------
    logic              clk            = 1'b0;
    logic              rst_n          = 1'b0;
    logic              in_valid       = 1'b0;
    logic              in_ready;
    logic [REQ_W-1:0]  req_type       = '0;
    logic [SIZE_W-1:0] size_bytes     = '0;
    logic [ADDR_W-1:0] address        = '0;
    logic              out_valid;
    logic              out_ready      = 1'b0;
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] result_address;
    logic              psel           = 1'b0;
    logic              penable        = 1'b0;
    logic              pwrite         = 1'b0;
    logic [2:0]        paddr          = '0;
    logic [31:0]       pwdata         = '0;
    logic [31:0]       prdata;
    logic              pready;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    first_fit_block_allocator_core #(
        .BLOCK_BYTES  (BLOCK_BYTES),
        .REGION_BYTES (REGION_BYTES)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .size_bytes     (size_bytes),
        .address        (address),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .result_address (result_address),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // ------------------------------------------------------------------
    // Shadow of the block: config registers and the run-length map.
    // The map holds a run length at the first block of each run.
    // ------------------------------------------------------------------
    logic [31:0] region_base_q = 32'h0;
    logic [31:0] take_base_q   = TAKE_BASE_RESET;
    bit   [15:0] run_map [NBLK];

    alloc_req_t  request_backlog[$];   // words waiting for the driver
    alloc_rsp_t  awaited_results[$];   // expected result words, oldest first
    int unsigned live_offsets[$];      // region offsets of granted areas, fodder for frees

    alloc_req_t  offered;              // word currently on the request port
    alloc_rsp_t  granted;
    alloc_rsp_t  want;

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int holds_asked     = 0;
    int holds_served    = 0;
    int hold_left       = 0;
    int bad_words       = 0;
    int readback_errors = 0;

    // Outcome of one request word; updates the shadow map as the block would.
    function automatic alloc_rsp_t allocator_outcome(input alloc_req_t rq);
        alloc_rsp_t        rsp;
        logic [ADDR_W-1:0] off;
        int unsigned       need;
        int unsigned       pos;
        int unsigned       k;
        int unsigned       blk;
        rsp.status         = ST_NOSPACE;
        rsp.result_address = '0;
        // block count, rounded up
        need = (32'(rq.size_bytes) + BLOCK_BYTES - 1) / BLOCK_BYTES;
        case (rq.kind)
            REQ_ALLOC:
            begin
                if (rq.size_bytes != 0 && need <= NBLK)
                begin
                    pos = 0;
                    // first fit: test a window, jump past any run met inside it
                    while (pos + need <= NBLK && rsp.status != ST_OK)
                    begin
                        k = 0;
                        while (k < need && run_map[pos + k] == 0)
                            k++;
                        if (k == need)
                        begin
                            run_map[pos]       = 16'(need);
                            rsp.status         = ST_OK;
                            rsp.result_address = region_base_q + 32'(pos * BLOCK_BYTES);
                        end
                        else
                        begin
                            pos = pos + k + run_map[pos + k];
                        end
                    end
                end
            end
            REQ_TAKE:
            begin
                off = rq.address - take_base_q;
                if (rq.size_bytes != 0)
                begin
                    if (off >= REGION_BYTES)
                    begin
                        rsp.status = ST_OUTSIDE;
                    end
                    else
                    begin
                        blk = off / BLOCK_BYTES;
                        // run is cut at the region end; no overlap check
                        if (need > NBLK - blk)
                            need = NBLK - blk;
                        run_map[blk]       = 16'(need);
                        rsp.status         = ST_OK;
                        rsp.result_address = region_base_q + off;
                    end
                end
            end
            REQ_FREE:
            begin
                off = rq.address - region_base_q;
                if (off >= REGION_BYTES)
                begin
                    rsp.status = ST_OUTSIDE;
                end
                else
                begin
                    run_map[off / BLOCK_BYTES] = '0;
                    rsp.status                 = ST_OK;
                end
            end
            default:
            begin
                rsp.status = ST_NOSPACE;
            end
        endcase
        return rsp;
    endfunction

    function automatic alloc_req_t make_request(input logic [REQ_W-1:0] kind,
                                                input logic [SIZE_W-1:0] size,
                                                input logic [ADDR_W-1:0] addr);
        alloc_req_t rq;
        rq.kind       = kind;
        rq.size_bytes = size;
        rq.address    = addr;
        return rq;
    endfunction

    // Random word. Mostly small allocations, takes in the low area and frees of
    // live areas, so the map stays populated; the rest is rejects and noise.
    function automatic alloc_req_t next_random_request();
        alloc_req_t  rq;
        int unsigned roll;
        int unsigned pick;
        int unsigned off;
        int          k;
        roll          = $urandom_range(99);
        rq.kind       = REQ_ALLOC;
        rq.size_bytes = SIZE_W'($urandom_range(1, 8 * BLOCK_BYTES));
        rq.address    = $urandom;
        if (roll < 38)
        begin
            pick = $urandom_range(19);
            if (pick == 0)
                rq.size_bytes = '0;
            else if (pick == 1)
                rq.size_bytes = {1'b1, 25'($urandom)};  // at least as many blocks as the region has
        end
        else if (roll < 60)
        begin
            rq.kind = REQ_TAKE;
            pick    = $urandom_range(19);
            if (pick < 15)
            begin
                off = $urandom_range(0, 512 * BLOCK_BYTES - 1);
            end
            else if (pick < 17)
            begin
                // near the end with any size: run gets cut
                off           = REGION_BYTES - $urandom_range(1, 64 * BLOCK_BYTES);
                rq.size_bytes = SIZE_W'($urandom);
            end
            else
            begin
                off           = $urandom;  // nearly always outside
                rq.size_bytes = SIZE_W'($urandom);
            end
            if (pick == 14)
                rq.size_bytes = '0;
            rq.address = take_base_q + off;
        end
        else if (roll < 94)
        begin
            rq.kind = REQ_FREE;
            pick    = $urandom_range(9);
            if (pick < 8 && live_offsets.size() > 0)
            begin
                k   = $urandom_range(live_offsets.size() - 1);
                off = (live_offsets[k] / BLOCK_BYTES) * BLOCK_BYTES
                      + $urandom_range(BLOCK_BYTES - 1);
                live_offsets.delete(k);
            end
            else if (pick < 9)
            begin
                off = $urandom_range(0, REGION_BYTES - 1);
            end
            else
            begin
                off = $urandom;
            end
            rq.address = region_base_q + off;
        end
        else
        begin
            rq.kind       = REQ_UNUSED;
            rq.size_bytes = SIZE_W'($urandom);
        end
        return rq;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers backlog words, predicts each one as it is accepted.
    // Valid is held with a stable payload until the handshake.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                granted = allocator_outcome(offered);
                awaited_results.push_back(granted);
                if (granted.status == ST_OK && offered.kind != REQ_FREE)
                    live_offsets.push_back(granted.result_address - region_base_q);
            end
            if (!in_valid || in_ready)
            begin
                if (request_backlog.size() > 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    offered    = request_backlog.pop_front();
                    in_valid   <= 1'b1;
                    req_type   <= offered.kind;
                    size_bytes <= offered.size_bytes;
                    address    <= offered.address;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks result words in order and drives out_ready. A long
    // hold-off, when asked for, is counted here so the block backs up.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result word with none outstanding: status %0d, result_address %h",
                           status, result_address);
                    bad_words++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        bad_words++;
                    end
                    if (result_address !== want.result_address)
                    begin
                        $error("result_address: expected %h, got %h",
                               want.result_address, result_address);
                        bad_words++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (holds_served != holds_asked)
            begin
                holds_served <= holds_asked;
                hold_left    <= LONG_HOLD;
                out_ready    <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Config port and stimulus helpers
    // ------------------------------------------------------------------
    task automatic apb_xfer(input logic wr, input logic idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write a register, mirror it in the shadow, read it back.
    task automatic set_register(input logic idx, input logic [31:0] value);
        logic [31:0] readback;
        apb_xfer(1'b1, idx, value, readback);
        if (idx == CFG_REGION_BASE)
            region_base_q = value;
        else
            take_base_q = value;
        apb_xfer(1'b0, idx, '0, readback);
        if (readback !== value)
        begin
            $error("%s readback: expected %h, got %h",
                   (idx == CFG_REGION_BASE) ? "region_base" : "take_base", value, readback);
            readback_errors++;
        end
    endtask

    task automatic offer(input alloc_req_t rq);
        @(negedge clk);
        while (request_backlog.size() >= BACKLOG_MAX)
            @(negedge clk);
        request_backlog.push_back(rq);
    endtask

    // Sender pause: nothing queued, nothing on the port, nothing outstanding.
    task automatic wait_drained();
        while (request_backlog.size() != 0 || in_valid || awaited_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic run_phase(input int words, input int idle_pct, input int stall_pct,
                             input bit with_hold);
        @(negedge clk);
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        for (int i = 0; i < words; i++)
        begin
            if (with_hold && i == words / 3)
                holds_asked++;
            if (i == words / 2)
                wait_drained();
            offer(next_random_request());
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words at reset config; the map starts empty. The first
        // words wait out the clearing sweep behind in_ready.
        offer(make_request(REQ_ALLOC, '0, '0));                          // zero size
        offer(make_request(REQ_ALLOC, SIZE_W'(REGION_BYTES), '0));       // whole region
        offer(make_request(REQ_ALLOC, SIZE_W'(1), '0));                  // region full
        offer(make_request(REQ_FREE, '0, region_base_q));
        offer(make_request(REQ_ALLOC, SIZE_W'(1), '0));
        offer(make_request(REQ_ALLOC, SIZE_W'(BLOCK_BYTES + 1), '0));    // rounds up to 2
        offer(make_request(REQ_ALLOC, {SIZE_W{1'b1}}, '0));              // exceeds block count
        offer(make_request(REQ_TAKE, '0, take_base_q));                  // zero size take
        offer(make_request(REQ_TAKE, SIZE_W'(1), take_base_q - 1));      // wraps, outside
        offer(make_request(REQ_TAKE, SIZE_W'(1), take_base_q + REGION_BYTES));
        offer(make_request(REQ_TAKE, {SIZE_W{1'b1}}, take_base_q + REGION_BYTES - 1));
        offer(make_request(REQ_TAKE, SIZE_W'(3000), take_base_q + 5 * BLOCK_BYTES + 77));
        offer(make_request(REQ_TAKE, SIZE_W'(BLOCK_BYTES),
                           take_base_q + 6 * BLOCK_BYTES));             // overlap
        offer(make_request(REQ_ALLOC, SIZE_W'(4 * BLOCK_BYTES), '0));    // jumps several runs
        offer(make_request(REQ_FREE, '0, region_base_q + 2 * BLOCK_BYTES)); // inside a run
        offer(make_request(REQ_FREE, '0, region_base_q + REGION_BYTES));
        offer(make_request(REQ_FREE, '0, region_base_q - 1));
        offer(make_request(REQ_FREE, '0, region_base_q + REGION_BYTES - 1));
        offer(make_request(REQ_UNUSED, {SIZE_W{1'b1}}, 32'hFFFF_FFFF));
        offer(make_request(REQ_TAKE, SIZE_W'(REGION_BYTES),
                           take_base_q + BLOCK_BYTES));                 // to the end
        offer(make_request(REQ_ALLOC, SIZE_W'(2 * BLOCK_BYTES), '0));    // no gap fits
        offer(make_request(REQ_FREE, '0, region_base_q + BLOCK_BYTES));
        offer(make_request(REQ_ALLOC, SIZE_W'(2 * BLOCK_BYTES), 32'hFFFF_FFFF));
        wait_drained();

        // Random phases; registers change only while the block is drained.
        set_register(CFG_REGION_BASE, 32'hFFFF_FC00);   // granted addresses wrap
        set_register(CFG_TAKE_BASE, 32'h0000_0000);
        run_phase(110, 0, 0, 1'b0);

        set_register(CFG_REGION_BASE, 32'h8000_0000);
        set_register(CFG_TAKE_BASE, 32'hFFFF_FFFF);
        run_phase(110, 68, 0, 1'b0);

        set_register(CFG_REGION_BASE, 32'hFFFF_FFFF);
        set_register(CFG_TAKE_BASE, $urandom);
        run_phase(115, 0, 68, 1'b1);

        set_register(CFG_REGION_BASE, 32'h0000_0000);
        set_register(CFG_TAKE_BASE, $urandom);
        run_phase(115, 14, 14, 1'b0);

        repeat (20) @(posedge clk);
        if (bad_words == 0 && readback_errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog, far past the slowest legal run including the clearing sweep.
    initial
    begin
        #96000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/ffba_pkg.sv
sv/ffba_run_map.sv
sv/first_fit_block_allocator_core.sv
dv/tb.sv
